// ===== sv/hpq_pkg.sv =====
// Shared types, field widths and codes for the indexed binary min-heap queue.
// Used by every module of the block; depends on nothing else.
package hpq_pkg;

   localparam int DEF_QUEUE_DEPTH = 64;
   localparam int DEF_KEY_BITS    = 32;
   localparam int DEF_VALUE_BITS  = 32;

   localparam int OPCODE_W   = 3;
   localparam int PRIO_W     = 32;
   localparam int PAYLOAD_W  = 32;
   localparam int HANDLE_W   = 6;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 7;
   localparam int CAP_W      = 7;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int FIFO_DEPTH = 2;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
   localparam logic [CSR_ADDR_W-1:0] REG_CAPACITY = 3'd0;

   localparam logic [OPCODE_W-1:0] OPC_INSERT   = 3'd0;
   localparam logic [OPCODE_W-1:0] OPC_DECREASE = 3'd1;
   localparam logic [OPCODE_W-1:0] OPC_INCREASE = 3'd2;
   localparam logic [OPCODE_W-1:0] OPC_DEL_MIN  = 3'd3;
   localparam logic [OPCODE_W-1:0] OPC_READ_MIN = 3'd4;

   localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_STALE     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_UNCHANGED = 3'd4;

   typedef enum logic [2:0] {
      OP_INSERT,
      OP_DECREASE,
      OP_INCREASE,
      OP_DELETE_MIN,
      OP_READ_MIN
   } op_kind_type;

   typedef struct packed {
      op_kind_type            op;
      logic [PRIO_W-1:0]      priority_req;
      logic [PAYLOAD_W-1:0]   payload;
      logic [HANDLE_W-1:0]    handle;
   } req_item_type;

endpackage

// ===== sv/hpq_front.sv =====
// Front end: takes request words, decodes the opcode and trims key and payload.
// Depends on hpq_pkg; feeds hpq_fifo.
module hpq_front
   import hpq_pkg::*;
#(
   parameter int KEY_BITS   = DEF_KEY_BITS,
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [OPCODE_W-1:0]  req_opcode,
   input  logic [PRIO_W-1:0]    req_priority_req,
   input  logic [PAYLOAD_W-1:0] req_payload,
   input  logic [HANDLE_W-1:0]  req_handle,
   input  logic                 fifo_full,
   output logic                 push,
   output req_item_type         push_item
);

   localparam logic [63:0] KEY_MASK   = ~64'd0 >> (64 - KEY_BITS);
   localparam logic [63:0] VALUE_MASK = ~64'd0 >> (64 - VALUE_BITS);

   op_kind_type op_kind;

   // Opcodes past delete minimum behave as read minimum.
   always_comb begin
      case (req_opcode)
         OPC_INSERT:   op_kind = OP_INSERT;
         OPC_DECREASE: op_kind = OP_DECREASE;
         OPC_INCREASE: op_kind = OP_INCREASE;
         OPC_DEL_MIN:  op_kind = OP_DELETE_MIN;
         default:      op_kind = OP_READ_MIN;
      endcase
   end

   assign req_stall = fifo_full;
   assign push      = req_valid && !fifo_full;

   assign push_item.op           = op_kind;
   assign push_item.priority_req = req_priority_req & KEY_MASK[PRIO_W-1:0];
   assign push_item.payload      = req_payload & VALUE_MASK[PAYLOAD_W-1:0];
   assign push_item.handle       = req_handle;

endmodule

// ===== sv/hpq_fifo.sv =====
// Short queue between the front end and the heap engine.
// Depends on hpq_pkg for its depth and word type.
module hpq_fifo
   import hpq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  req_item_type push_item,
   output logic         full,
   input  logic         pop,
   output logic         empty,
   output req_item_type head
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   req_item_type       slot_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;

   assign full  = (fill_ff == CNT_W'(FIFO_DEPTH));
   assign empty = (fill_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== sv/hpq_back.sv =====
// Heap engine: keeps the heap, handle pool and payloads in memories and runs
// each operation, sifts included, as a sequence of read and write steps.
// Depends on hpq_pkg; pops words from hpq_fifo.
module hpq_back
   import hpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int KEY_BITS    = DEF_KEY_BITS,
   parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [CAP_W-1:0]     cap_limit,
   input  logic                 fifo_empty,
   input  req_item_type         fifo_head,
   output logic                 fifo_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [HANDLE_W-1:0]  rsp_new_handle,
   output logic [COUNT_W-1:0]   rsp_entry_count,
   output logic                 rsp_min_valid,
   output logic [PRIO_W-1:0]    rsp_min_priority,
   output logic [PAYLOAD_W-1:0] rsp_min_payload
);

   localparam int HDL_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int LW    = HDL_W + 1;
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int HX_W  = (HDL_W > HANDLE_W) ? HDL_W : HANDLE_W;

   typedef enum logic [3:0] {
      S_IDLE, S_DISP, S_INS, S_RK1, S_RK2, S_DL1, S_DL2,
      S_UP_RD, S_UP_CMP, S_DN_RL, S_DN_RR, S_DN_CMP,
      S_FIN0, S_FIN1, S_FIN2
   } state_type;

   // Memories: key and handle by heap position, slot and payload by handle.
   logic [KEY_BITS-1:0]   hkey_mem [QUEUE_DEPTH];
   logic [HDL_W-1:0]      hhdl_mem [QUEUE_DEPTH];
   logic [HDL_W-1:0]      slot_mem [QUEUE_DEPTH];
   logic [VALUE_BITS-1:0] val_mem  [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] hv_ff;

   logic [KEY_BITS-1:0]   hk_rd;
   logic [HDL_W-1:0]      hh_rd;
   logic [HDL_W-1:0]      sl_rd;
   logic [VALUE_BITS-1:0] vl_rd;

   logic [HDL_W-1:0]      ha, sa, va;
   logic                  hw_en, sw_en, vw_en;
   logic [HDL_W-1:0]      hw_addr, sw_addr, sw_data, vw_addr, hw_hdl;
   logic [KEY_BITS-1:0]   hw_key;
   logic [VALUE_BITS-1:0] vw_data;

   state_type             state_ff, state_in;
   op_kind_type           op_ff, op_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [HANDLE_W-1:0]   hdl_ff, hdl_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [HDL_W-1:0]      nh_ff, nh_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [HDL_W-1:0]      pos_ff, pos_in;
   logic [KEY_BITS-1:0]   mk_ff, mk_in;
   logic [HDL_W-1:0]      mh_ff, mh_in;
   logic [KEY_BITS-1:0]   bk_ff, bk_in;
   logic [HDL_W-1:0]      bh_ff, bh_in;
   logic                  bsel_ff, bsel_in;
   logic [HDL_W-1:0]      rh_ff, rh_in;
   logic [KEY_BITS-1:0]   rootk_ff, rootk_in;
   logic [QUEUE_DEPTH-1:0] live_ff, live_in;

   logic                  out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0]   out_status_ff, out_status_in;
   logic [HANDLE_W-1:0]   out_nh_ff, out_nh_in;
   logic [COUNT_W-1:0]    out_cnt_ff, out_cnt_in;
   logic                  out_mv_ff, out_mv_in;
   logic [PRIO_W-1:0]     out_key_ff, out_key_in;
   logic [PAYLOAD_W-1:0]  out_val_ff, out_val_in;

   logic [CMP_W-1:0]      cap_eff;
   logic [HX_W-1:0]       hx;
   logic                  hdl_ok;
   logic [HDL_W-1:0]      hidx;
   logic [LW-1:0]         lpos, rpos, cnt_l;
   logic [KEY_BITS-1:0]   cur_best;
   logic [63:0]           key_wide, val_wide;
   logic                  out_free;

   assign cap_eff  = (CMP_W'(cap_limit) > CMP_W'(QUEUE_DEPTH)) ?
                     CMP_W'(QUEUE_DEPTH) : CMP_W'(cap_limit);
   assign hx       = HX_W'(hdl_ff);
   // One extra bit so that a depth equal to 2**HX_W still compares correctly.
   assign hdl_ok   = ({1'b0, hx} < (HX_W + 1)'(QUEUE_DEPTH));
   assign hidx     = hx[HDL_W-1:0];
   assign lpos     = {pos_ff, 1'b0};
   assign rpos     = {pos_ff, 1'b1};
   assign cnt_l    = LW'(cnt_ff);
   assign cur_best = bsel_ff ? bk_ff : mk_ff;
   assign key_wide = 64'(rootk_ff);
   assign val_wide = 64'(vl_rd);
   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      val_in    = val_ff;
      hdl_in    = hdl_ff;
      status_in = status_ff;
      nh_in     = nh_ff;
      cnt_in    = cnt_ff;
      pos_in    = pos_ff;
      mk_in     = mk_ff;
      mh_in     = mh_ff;
      bk_in     = bk_ff;
      bh_in     = bh_ff;
      bsel_in   = bsel_ff;
      rh_in     = rh_ff;
      rootk_in  = rootk_ff;
      live_in   = live_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_status_in = out_status_ff;
      out_nh_in     = out_nh_ff;
      out_cnt_in    = out_cnt_ff;
      out_mv_in     = out_mv_ff;
      out_key_in    = out_key_ff;
      out_val_in    = out_val_ff;
      fifo_pop = 1'b0;
      ha = '0;
      sa = '0;
      va = '0;
      hw_en = 1'b0;
      hw_addr = pos_ff;
      hw_key  = mk_ff;
      hw_hdl  = mh_ff;
      sw_en   = 1'b0;
      sw_addr = mh_ff;
      sw_data = pos_ff;
      vw_en   = 1'b0;
      vw_addr = hh_rd;
      vw_data = val_ff;

      case (state_ff)
         S_IDLE: begin
            if (!fifo_empty) begin
               fifo_pop  = 1'b1;
               op_in     = fifo_head.op;
               key_in    = KEY_BITS'(fifo_head.priority_req);
               val_in    = VALUE_BITS'(fifo_head.payload);
               hdl_in    = fifo_head.handle;
               status_in = ST_DONE;
               nh_in     = '0;
               state_in  = S_DISP;
            end
         end
         S_DISP: begin
            case (op_ff)
               OP_INSERT: begin
                  if (CMP_W'(cnt_ff) >= cap_eff) begin
                     status_in = ST_FULL;
                     state_in  = S_FIN0;
                  end else begin
                     ha       = cnt_ff[HDL_W-1:0];
                     state_in = S_INS;
                  end
               end
               OP_DECREASE, OP_INCREASE: begin
                  if (!hdl_ok || !live_ff[hidx]) begin
                     status_in = ST_STALE;
                     state_in  = S_FIN0;
                  end else begin
                     sa       = hidx;
                     state_in = S_RK1;
                  end
               end
               OP_DELETE_MIN: begin
                  if (cnt_ff == '0) begin
                     status_in = ST_EMPTY;
                     state_in  = S_FIN0;
                  end else begin
                     ha       = '0;
                     state_in = S_DL1;
                  end
               end
               default: begin
                  if (cnt_ff == '0) begin
                     status_in = ST_EMPTY;
                  end
                  state_in = S_FIN0;
               end
            endcase
         end
         S_INS: begin
            // The handle parked at the first free position is allocated.
            vw_en   = 1'b1;
            vw_addr = hh_rd;
            vw_data = val_ff;
            live_in[hh_rd] = 1'b1;
            nh_in    = hh_rd;
            mk_in    = key_ff;
            mh_in    = hh_rd;
            pos_in   = cnt_ff[HDL_W-1:0];
            cnt_in   = cnt_ff + 1'b1;
            state_in = S_UP_RD;
         end
         S_RK1: begin
            ha       = sl_rd;
            pos_in   = sl_rd;
            state_in = S_RK2;
         end
         S_RK2: begin
            if ((op_ff == OP_DECREASE) ? (key_ff >= hk_rd) : (key_ff <= hk_rd)) begin
               status_in = ST_UNCHANGED;
               state_in  = S_FIN0;
            end else begin
               mk_in    = key_ff;
               mh_in    = hidx;
               state_in = (op_ff == OP_DECREASE) ? S_UP_RD : S_DN_RL;
            end
         end
         S_DL1: begin
            rh_in    = hh_rd;
            ha       = HDL_W'(cnt_ff - 1'b1);
            state_in = S_DL2;
         end
         S_DL2: begin
            // Old root handle returns to the pool at the old last position.
            hw_en   = 1'b1;
            hw_addr = HDL_W'(cnt_ff - 1'b1);
            hw_key  = hk_rd;
            hw_hdl  = rh_ff;
            live_in[rh_ff] = 1'b0;
            cnt_in  = cnt_ff - 1'b1;
            mk_in   = hk_rd;
            mh_in   = hh_rd;
            pos_in  = '0;
            state_in = (cnt_ff == CNT_W'(1)) ? S_FIN0 : S_DN_RL;
         end
         S_UP_RD: begin
            if (pos_ff == '0) begin
               hw_en    = 1'b1;
               sw_en    = 1'b1;
               state_in = S_FIN0;
            end else begin
               ha       = pos_ff >> 1;
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            hw_en = 1'b1;
            sw_en = 1'b1;
            if (mk_ff < hk_rd) begin
               hw_key   = hk_rd;
               hw_hdl   = hh_rd;
               sw_addr  = hh_rd;
               pos_in   = pos_ff >> 1;
               state_in = S_UP_RD;
            end else begin
               state_in = S_FIN0;
            end
         end
         S_DN_RL: begin
            ha       = lpos[HDL_W-1:0];
            bsel_in  = 1'b0;
            state_in = S_DN_RR;
         end
         S_DN_RR: begin
            ha = rpos[HDL_W-1:0];
            // At the root the left child index is the root itself.
            if ((lpos < cnt_l) && (pos_ff != '0) && (hk_rd < mk_ff)) begin
               bsel_in = 1'b1;
               bk_in   = hk_rd;
               bh_in   = hh_rd;
            end
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            hw_en = 1'b1;
            sw_en = 1'b1;
            if ((rpos < cnt_l) && (hk_rd < cur_best)) begin
               hw_key   = hk_rd;
               hw_hdl   = hh_rd;
               sw_addr  = hh_rd;
               pos_in   = rpos[HDL_W-1:0];
               state_in = S_DN_RL;
            end else if (bsel_ff) begin
               hw_key   = bk_ff;
               hw_hdl   = bh_ff;
               sw_addr  = bh_ff;
               pos_in   = lpos[HDL_W-1:0];
               state_in = S_DN_RL;
            end else begin
               state_in = S_FIN0;
            end
         end
         S_FIN0: begin
            ha       = '0;
            state_in = S_FIN1;
         end
         S_FIN1: begin
            rootk_in = hk_rd;
            rh_in    = hh_rd;
            va       = hh_rd;
            state_in = S_FIN2;
         end
         S_FIN2: begin
            va = rh_ff;
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = status_ff;
               out_nh_in     = HANDLE_W'(nh_ff);
               out_cnt_in    = COUNT_W'(cnt_ff);
               out_mv_in     = (cnt_ff != '0);
               out_key_in    = (cnt_ff != '0) ? key_wide[PRIO_W-1:0] : '0;
               out_val_in    = (cnt_ff != '0) ? val_wide[PAYLOAD_W-1:0] : '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         live_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         live_ff      <= live_in;
         out_valid_ff <= out_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      hdl_ff        <= hdl_in;
      status_ff     <= status_in;
      nh_ff         <= nh_in;
      pos_ff        <= pos_in;
      mk_ff         <= mk_in;
      mh_ff         <= mh_in;
      bk_ff         <= bk_in;
      bh_ff         <= bh_in;
      bsel_ff       <= bsel_in;
      rh_ff         <= rh_in;
      rootk_ff      <= rootk_in;
      out_status_ff <= out_status_in;
      out_nh_ff     <= out_nh_in;
      out_cnt_ff    <= out_cnt_in;
      out_mv_ff     <= out_mv_in;
      out_key_ff    <= out_key_in;
      out_val_ff    <= out_val_in;
   end

   // A position never written still holds its reset handle, its own index.
   always_ff @(posedge clock) begin
      if (reset) begin
         hv_ff <= '0;
      end else if (hw_en) begin
         hv_ff[hw_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (hw_en) begin
         hkey_mem[hw_addr] <= hw_key;
         hhdl_mem[hw_addr] <= hw_hdl;
      end
      hk_rd <= hkey_mem[ha];
      hh_rd <= hv_ff[ha] ? hhdl_mem[ha] : ha;
   end

   always_ff @(posedge clock) begin
      if (sw_en) begin
         slot_mem[sw_addr] <= sw_data;
      end
      sl_rd <= slot_mem[sa];
   end

   always_ff @(posedge clock) begin
      if (vw_en) begin
         val_mem[vw_addr] <= vw_data;
      end
      vl_rd <= val_mem[va];
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_new_handle   = out_nh_ff;
   assign rsp_entry_count  = out_cnt_ff;
   assign rsp_min_valid    = out_mv_ff;
   assign rsp_min_priority = out_key_ff;
   assign rsp_min_payload  = out_val_ff;

endmodule

// ===== sv/indexed_binary_min_heap_queue_core.sv =====
// Read minimum and rejected words go from dispatch straight to the finish steps, which read
// the root and offer the result word; a re-key first reads the handle's slot and key, and a
// re-key that changes nothing finishes at once. A sift climbs or descends one level at a time,
// through at most all seven levels of a full 64-entry heap, before the finish steps.
// The heap engine handles one word at a time and holds each until its result can enter the
// output register past any result stall; the front queue keeps taking up to two words meanwhile.
// Reset (synchronous, active high): queue empty, every handle free, capacity 64.
// No clearing pass is needed: unwritten heap positions read as their own index.
module indexed_binary_min_heap_queue_core
   import hpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int KEY_BITS    = DEF_KEY_BITS,
   parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [OPCODE_W-1:0]   req_opcode,
   input  logic [PRIO_W-1:0]     req_priority_req,
   input  logic [PAYLOAD_W-1:0]  req_payload,
   input  logic [HANDLE_W-1:0]   req_handle,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [HANDLE_W-1:0]   rsp_new_handle,
   output logic [COUNT_W-1:0]    rsp_entry_count,
   output logic                  rsp_min_valid,
   output logic [PRIO_W-1:0]     rsp_min_priority,
   output logic [PAYLOAD_W-1:0]  rsp_min_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // The capacity register is the only control register; it sits at offset zero.
   logic [CAP_W-1:0] cap_ff, cap_in;
   logic             cap_hit;

   logic         fifo_full, fifo_empty, push, pop;
   req_item_type push_item, head_item;

   assign cap_hit    = (csr_paddr[CSR_ADDR_W-1:2] == REG_CAPACITY[CSR_ADDR_W-1:2]);
   assign csr_pready = 1'b1;
   assign csr_prdata = cap_hit ? CSR_DATA_W'(cap_ff) : '0;

   always_comb begin
      cap_in = cap_ff;
      if (csr_psel && csr_penable && csr_pwrite && cap_hit) begin
         cap_in = csr_pwdata[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   // The front end decodes each word and parks it in a two-word queue, so
   // the upstream side can hand over up to two words while the heap engine is in a sift.
   hpq_front #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_priority_req (req_priority_req),
      .req_payload      (req_payload),
      .req_handle       (req_handle),
      .fifo_full        (fifo_full),
      .push             (push),
      .push_item        (push_item)
   );

   hpq_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (fifo_full),
      .pop       (pop),
      .empty     (fifo_empty),
      .head      (head_item)
   );

   // The engine finishes each operation into an output register and can
   // start the next word while that result still waits downstream.
   hpq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .KEY_BITS    (KEY_BITS),
      .VALUE_BITS  (VALUE_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cap_limit        (cap_ff),
      .fifo_empty       (fifo_empty),
      .fifo_head        (head_item),
      .fifo_pop         (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_new_handle   (rsp_new_handle),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_min_valid    (rsp_min_valid),
      .rsp_min_priority (rsp_min_priority),
      .rsp_min_payload  (rsp_min_payload)
   );

endmodule

// ===== sv/hpq_checker.sv =====
// Port-level checks on the result channel of the heap queue, bound to the top.
// Depends on hpq_pkg for status codes and widths.
module hpq_checker
   import hpq_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [STATUS_W-1:0]  rsp_status,
   input logic [HANDLE_W-1:0]  rsp_new_handle,
   input logic [COUNT_W-1:0]   rsp_entry_count,
   input logic                 rsp_min_valid,
   input logic [PRIO_W-1:0]    rsp_min_priority,
   input logic [PAYLOAD_W-1:0] rsp_min_payload
);

   a_valid_tracks_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_min_valid == (rsp_entry_count != '0)))
      else $error("min_valid disagrees with entry count");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_min_valid) |-> (rsp_min_priority == '0 && rsp_min_payload == '0))
      else $error("empty queue shows a root entry");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |-> (rsp_entry_count == '0))
      else $error("empty status with entries held");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status)
                                    && $stable(rsp_new_handle)))
      else $error("stalled result changed");

endmodule

bind indexed_binary_min_heap_queue_core hpq_checker u_hpq_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_new_handle   (rsp_new_handle),
   .rsp_entry_count  (rsp_entry_count),
   .rsp_min_valid    (rsp_min_valid),
   .rsp_min_priority (rsp_min_priority),
   .rsp_min_payload  (rsp_min_payload)
);
